[rtl/csse_pkg.sv]
// Shared types and constants for the cache slot sweep evictor.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none
package csse_pkg;

	localparam int SLOT_DEPTH = 256;
	localparam int SLOT_AW = $clog2(SLOT_DEPTH);

	localparam int IDX_W = 8;
	localparam int EP_W = 32;
	localparam int THR_W = 7;
	localparam int CNT_W = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W = 9;

	localparam int PCT_SCALE = 100;
	localparam int PROD_W = 16;
	localparam int EVICT_SHIFT = 2;
	localparam int TGT_W = CNT_W - EVICT_SHIFT;
	localparam int MOD_W = IDX_W + CNT_W;
	localparam int MOD_KW = $clog2(IDX_W);

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(80);
	localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(256);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 1'd1;

	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_TOMB = 2'd1;
	localparam logic [1:0] ST_LIVE = 2'd2;

	localparam logic RD_SIDX = 1'b0;
	localparam logic RD_CUR = 1'b1;

	localparam logic [1:0] OUT_UPD = 2'd0;
	localparam logic [1:0] OUT_MID = 2'd1;
	localparam logic [1:0] OUT_FIN = 2'd2;

	typedef struct packed {
		logic       ld_item;
		logic       rd_en;
		logic       rd_src;
		logic       upd_wr;
		logic       ev_mul;
		logic       mod_step;
		logic       sweep;
		logic       fin;
		logic       push;
		logic [1:0] out_sel;
	} cmd_t;

	typedef struct packed {
		logic ev_go;
		logic mod_last;
		logic need_out;
		logic sweep_end;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/csse_if.sv]
// Valid/ready channel interfaces for update and eviction requests and their results.
// Depends on csse_pkg for the field widths.
`default_nettype none
interface csse_req_if;
	import csse_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [IDX_W-1:0]     slot_idx;
	logic [EP_W-1:0]      guard_ep;
	logic [EP_W-1:0]      vis_ep;
	logic                 valid_flag;
	logic                 tombstone_flag;

	modport source(output valid, func, slot_idx, guard_ep, vis_ep,
		valid_flag, tombstone_flag, input ready);
	modport sink(input valid, func, slot_idx, guard_ep, vis_ep,
		valid_flag, tombstone_flag, output ready);
endinterface

interface csse_rsp_if;
	import csse_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 evicted;
	logic [IDX_W-1:0]     evicted_slot;
	logic [CNT_W-1:0]     live_count;
	logic                 last_result;

	modport source(output valid, evicted, evicted_slot, live_count, last_result,
		input ready);
	modport sink(input valid, evicted, evicted_slot, live_count, last_result,
		output ready);
endinterface
`default_nettype wire

[rtl/csse_ctrl.sv]
// Sequencing state machine: steps one item through an update or an eviction check and sweep.
// Depends on csse_pkg for the command and status structs.
`default_nettype none
module csse_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	input  wire              req_func,
	output logic             req_ready,
	input  csse_pkg::sts_t   sts,
	output csse_pkg::cmd_t   cmd
);
	import csse_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_UPD_RD   = 4'd1;
	localparam logic [3:0] S_UPD_WR   = 4'd2;
	localparam logic [3:0] S_UPD_OUT  = 4'd3;
	localparam logic [3:0] S_EV_MUL   = 4'd4;
	localparam logic [3:0] S_EV_CMP   = 4'd5;
	localparam logic [3:0] S_EV_NONE  = 4'd6;
	localparam logic [3:0] S_EV_MOD   = 4'd7;
	localparam logic [3:0] S_EV_START = 4'd8;
	localparam logic [3:0] S_EV_SWEEP = 4'd9;
	localparam logic [3:0] S_EV_FIN   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.ld_item = 1'b1;
					state_d = req_func ? S_EV_MUL : S_UPD_RD;
				end
			end
			S_UPD_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_src = RD_SIDX;
				state_d = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				state_d = S_UPD_OUT;
			end
			S_UPD_OUT: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.out_sel = OUT_UPD;
					state_d = S_IDLE;
				end
			end
			S_EV_MUL: begin
				cmd.ev_mul = 1'b1;
				state_d = S_EV_CMP;
			end
			S_EV_CMP: begin
				state_d = sts.ev_go ? S_EV_MOD : S_EV_NONE;
			end
			S_EV_NONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.out_sel = OUT_FIN;
					state_d = S_IDLE;
				end
			end
			S_EV_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = S_EV_START;
				end
			end
			S_EV_START: begin
				cmd.rd_en = 1'b1;
				cmd.rd_src = RD_CUR;
				state_d = S_EV_SWEEP;
			end
			S_EV_SWEEP: begin
				// A found slot first flushes the previously held result.
				if (!sts.need_out || sts.out_free) begin
					cmd.sweep = 1'b1;
					cmd.push = sts.need_out;
					cmd.out_sel = OUT_MID;
					if (sts.sweep_end) begin
						state_d = S_EV_FIN;
					end
				end
			end
			S_EV_FIN: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.out_sel = OUT_FIN;
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[rtl/csse_dp.sv]
// Datapath: configuration registers, slot state memory, live count, sweep cursor,
// threshold products, cursor modulo unit and the result register. Uses csse_pkg.
`default_nettype none
module csse_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [csse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [csse_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire  [csse_pkg::IDX_W-1:0]     req_slot_idx,
	input  wire  [csse_pkg::EP_W-1:0]      req_guard_ep,
	input  wire  [csse_pkg::EP_W-1:0]      req_vis_ep,
	input  wire                            req_valid_flag,
	input  wire                            req_tombstone_flag,
	input  wire                            rsp_ready,
	output logic                           rsp_valid,
	output logic                           rsp_evicted,
	output logic [csse_pkg::IDX_W-1:0]     rsp_evicted_slot,
	output logic [csse_pkg::CNT_W-1:0]     rsp_live_count,
	output logic                           rsp_last_result,
	input  csse_pkg::cmd_t                 cmd,
	output csse_pkg::sts_t                 sts
);
	import csse_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  slots_q;
	logic [CNT_W-1:0]  total;

	logic [IDX_W-1:0]  sidx_q;
	logic              hdr_ok_q;
	logic              tomb_q;
	logic              in_range;

	logic [CNT_W-1:0]  live_q;
	logic [IDX_W-1:0]  cursor_q;

	logic [1:0]        mem_q [SLOT_DEPTH];
	logic              vld_q [SLOT_DEPTH];
	logic [1:0]        rd_q;
	logic              rd_en;
	logic [SLOT_AW-1:0] rd_addr;
	logic              mem_we;
	logic [SLOT_AW-1:0] wr_addr;

	logic [PROD_W-1:0] prod_live_q;
	logic [PROD_W-1:0] prod_thr_q;
	logic [TGT_W-1:0]  target_q;
	logic [TGT_W-1:0]  target_init;
	logic [IDX_W-1:0]  cur_q;
	logic [MOD_KW-1:0] k_q;
	logic [MOD_W-1:0]  mod_sub;
	logic [CNT_W-1:0]  visited_q;
	logic [CNT_W-1:0]  visited_inc;
	logic [CNT_W-1:0]  cur_inc;
	logic [IDX_W-1:0]  cur_adv;

	logic              pend_q;
	logic [IDX_W-1:0]  pend_slot_q;
	logic [CNT_W-1:0]  pend_live_q;

	logic [1:0]        wr_state;
	logic [CNT_W-1:0]  live_nx;
	logic              slot_full;
	logic              live_we;

	assign total = (slots_q > CNT_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH) : slots_q;
	assign in_range = {1'b0, sidx_q} < total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			slots_q <= SLOTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				REG_SLOTS: slots_q <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			sidx_q <= req_slot_idx;
			hdr_ok_q <= (req_guard_ep == req_vis_ep) && req_valid_flag;
			tomb_q <= req_tombstone_flag;
		end
	end

	// Slot state memory; a slot never written since reset reads as empty.
	assign slot_full = (rd_q != ST_EMPTY);
	assign wr_state = cmd.upd_wr ? (hdr_ok_q ? (tomb_q ? ST_TOMB : ST_LIVE) : ST_EMPTY)
		: ST_EMPTY;
	assign mem_we = (cmd.upd_wr && in_range) || (cmd.sweep && slot_full);
	assign wr_addr = cmd.upd_wr ? sidx_q[SLOT_AW-1:0] : cur_q[SLOT_AW-1:0];
	assign rd_en = cmd.rd_en || cmd.sweep;
	assign rd_addr = cmd.sweep ? cur_adv[SLOT_AW-1:0]
		: ((cmd.rd_src == RD_CUR) ? cur_q[SLOT_AW-1:0] : sidx_q[SLOT_AW-1:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (mem_we) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= vld_q[rd_addr] ? mem_q[rd_addr] : ST_EMPTY;
		end
	end

	always_comb begin
		live_nx = live_q;
		if (rd_q == ST_LIVE && wr_state != ST_LIVE) begin
			if (live_q != '0) begin
				live_nx = live_q - CNT_W'(1);
			end
		end else if (rd_q != ST_LIVE && wr_state == ST_LIVE) begin
			live_nx = live_q + CNT_W'(1);
		end
	end
	assign live_we = mem_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			cursor_q <= '0;
		end else begin
			if (live_we) begin
				live_q <= live_nx;
			end
			if (cmd.fin) begin
				cursor_q <= cur_q;
			end
		end
	end

	// Eviction setup, cursor reduction modulo the slot count, and the sweep.
	assign target_init = (live_q[CNT_W-1:EVICT_SHIFT] == '0) ? TGT_W'(1)
		: live_q[CNT_W-1:EVICT_SHIFT];
	assign mod_sub = MOD_W'(total) << k_q;
	assign visited_inc = visited_q + CNT_W'(1);
	assign cur_inc = {1'b0, cur_q} + CNT_W'(1);
	assign cur_adv = (cur_inc == total) ? '0 : cur_inc[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.ev_mul) begin
			prod_live_q <= PROD_W'(live_q) * PROD_W'(PCT_SCALE);
			prod_thr_q <= PROD_W'(thr_q) * PROD_W'(total);
			target_q <= target_init;
			cur_q <= cursor_q;
			k_q <= MOD_KW'(IDX_W - 1);
			visited_q <= '0;
		end else if (cmd.mod_step) begin
			if (MOD_W'(cur_q) >= mod_sub) begin
				cur_q <= cur_q - mod_sub[IDX_W-1:0];
			end
			k_q <= k_q - MOD_KW'(1);
		end else if (cmd.sweep) begin
			if (slot_full) begin
				target_q <= target_q - TGT_W'(1);
				pend_slot_q <= cur_q;
				pend_live_q <= live_nx;
			end
			cur_q <= cur_adv;
			visited_q <= visited_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.ev_mul) begin
			pend_q <= 1'b0;
		end else if (cmd.sweep && slot_full) begin
			pend_q <= 1'b1;
		end
	end

	// Result register: one item held until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.push) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			case (cmd.out_sel)
				OUT_UPD: begin
					rsp_evicted <= 1'b0;
					rsp_evicted_slot <= sidx_q;
					rsp_live_count <= live_q;
					rsp_last_result <= 1'b1;
				end
				OUT_MID: begin
					rsp_evicted <= 1'b1;
					rsp_evicted_slot <= pend_slot_q;
					rsp_live_count <= pend_live_q;
					rsp_last_result <= 1'b0;
				end
				default: begin
					rsp_evicted <= pend_q;
					rsp_evicted_slot <= pend_q ? pend_slot_q : '0;
					rsp_live_count <= pend_q ? pend_live_q : live_q;
					rsp_last_result <= 1'b1;
				end
			endcase
		end
	end

	assign sts.ev_go = (total != '0) && (prod_live_q >= prod_thr_q);
	assign sts.mod_last = (k_q == '0);
	assign sts.need_out = slot_full && pend_q;
	assign sts.sweep_end = (visited_inc == total) || (slot_full && target_q == TGT_W'(1));
	assign sts.out_free = !rsp_valid || rsp_ready;

endmodule
`default_nettype wire

[rtl/cache_slot_sweep_evictor_core.sv]
// Cache slot sweep evictor, top level.
// Channel req (valid/ready) takes one item at a time: func 0 updates one slot's
// state from its header facts, func 1 asks for an eviction check. Channel rsp
// (valid/ready) returns the results; the last result of each item has
// last_result set. The plain write port cfg_we/cfg_index/cfg_wdata sets the
// threshold percentage (index 0) and the number of slots in use (index 1).
// An update is stepped through a slot read, a slot write and the push of its result
// into the output register. An eviction check forms the threshold products, compares
// them and, with nothing to evict, presents its one result. A sweep first reduces the
// cursor modulo the slot count, then reads the first slot, visits the slots one after
// another (at most the slots in use) and ends with the last result.
// The next item is accepted once the last result is in the output register,
// even if that result is still waiting.
// Reset empties every slot through per-slot valid bits at once, clears the
// live count and cursor, and sets the registers to 80 percent and 256 slots.
// A stalled receiver holds the result register; the sweep waits on it.
// Depends on csse_pkg, csse_if, csse_ctrl and csse_dp.
`default_nettype none
module cache_slot_sweep_evictor_core (
	input  wire                            clk,
	input  wire                            arst_n,
	csse_req_if.sink                       req,
	csse_rsp_if.source                     rsp,
	input  wire                            cfg_we,
	input  wire  [csse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [csse_pkg::CFG_W-1:0]     cfg_wdata
);
	import csse_pkg::*;

	cmd_t cmd;
	sts_t sts;

	csse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	csse_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.req_slot_idx       (req.slot_idx),
		.req_guard_ep       (req.guard_ep),
		.req_vis_ep         (req.vis_ep),
		.req_valid_flag     (req.valid_flag),
		.req_tombstone_flag (req.tombstone_flag),
		.rsp_ready          (rsp.ready),
		.rsp_valid          (rsp.valid),
		.rsp_evicted        (rsp.evicted),
		.rsp_evicted_slot   (rsp.evicted_slot),
		.rsp_live_count     (rsp.live_count),
		.rsp_last_result    (rsp.last_result),
		.cmd                (cmd),
		.sts                (sts)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted again while an item is in progress");

	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("result register overwritten while still held");

	a_plain_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.evicted) |-> rsp.last_result)
		else $error("non-eviction result not marked last");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.live_count <= CNT_W'(SLOT_DEPTH)))
		else $error("live count exceeds the slot depth");

endmodule
`default_nettype wire

[bench/csse_tb_pkg.sv]
// Bench-side codes and the result record shared by the checker and the bench top.
// Depends on csse_pkg for the field widths.
`default_nettype none
package csse_tb_pkg;
	import csse_pkg::*;

	localparam logic FN_UPDATE = 1'b0;
	localparam logic FN_EVICT = 1'b1;

	typedef struct packed {
		logic             evicted;
		logic [IDX_W-1:0] evicted_slot;
		logic [CNT_W-1:0] live_count;
		logic             last_result;
	} slot_report_t;

endpackage
`default_nettype wire

[bench/csse_slot_checker.sv]
// Checker for the cache slot sweep evictor: keeps its own copy of the slot states,
// live count, cursor and registers, predicts the results of each item and compares them.
// Depends on csse_pkg, csse_tb_pkg and the csse_req_if/csse_rsp_if channel interfaces.
`default_nettype none
module csse_slot_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	csse_req_if                           req,
	csse_rsp_if                           rsp,
	input  wire                           cfg_we,
	input  wire [csse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [csse_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            mismatches,
	output int                            awaiting
);
	import csse_pkg::*;
	import csse_tb_pkg::*;

	logic [1:0]       slot_st [SLOT_DEPTH];
	logic [CNT_W-1:0] live_slots;
	logic [IDX_W-1:0] cursor;
	logic [THR_W-1:0] thr_pct;
	logic [CNT_W-1:0] slots_cfg;
	slot_report_t     expected_reports [$];

	task automatic set_slot(input int idx, input logic [1:0] ns);
		logic [1:0] os;
		os = slot_st[idx];
		slot_st[idx] = ns;
		if (os == ST_LIVE && ns != ST_LIVE) begin
			if (live_slots != '0)
				live_slots = live_slots - CNT_W'(1);
		end else if (os != ST_LIVE && ns == ST_LIVE) begin
			live_slots = live_slots + CNT_W'(1);
		end
	endtask

	task automatic push_report(input logic ev, input logic [IDX_W-1:0] slot, input logic last);
		slot_report_t r;
		r.evicted = ev;
		r.evicted_slot = slot;
		r.live_count = live_slots;
		r.last_result = last;
		expected_reports.push_back(r);
	endtask

	task automatic predict_reports();
		int         total;
		int         target;
		int         visited;
		int         cur;
		int         emptied;
		logic [1:0] ns;
		total = (slots_cfg > SLOT_DEPTH) ? SLOT_DEPTH : int'(slots_cfg);
		if (req.func == FN_UPDATE) begin
			if (int'(req.slot_idx) < total) begin
				ns = ST_EMPTY;
				if (req.guard_ep == req.vis_ep && req.valid_flag)
					ns = req.tombstone_flag ? ST_TOMB : ST_LIVE;
				set_slot(int'(req.slot_idx), ns);
			end
			push_report(1'b0, req.slot_idx, 1'b1);
		end else if (total == 0 || int'(live_slots) * PCT_SCALE < int'(thr_pct) * total) begin
			push_report(1'b0, '0, 1'b1);
		end else begin
			target = int'(live_slots) >> EVICT_SHIFT;
			if (target == 0)
				target = 1;
			cur = int'(cursor) % total;
			emptied = 0;
			// At most one full pass over the slots in use per eviction item.
			for (visited = 0; visited < total && target > 0; visited++) begin
				if (slot_st[cur] != ST_EMPTY) begin
					set_slot(cur, ST_EMPTY);
					push_report(1'b1, IDX_W'(cur), 1'b0);
					emptied++;
					target--;
				end
				cur = (cur + 1) % total;
			end
			cursor = IDX_W'(cur);
			if (emptied == 0)
				push_report(1'b0, '0, 1'b1);
			else
				expected_reports[expected_reports.size() - 1].last_result = 1'b1;
		end
	endtask

	task automatic check_report();
		slot_report_t want;
		slot_report_t got;
		got.evicted = rsp.evicted;
		got.evicted_slot = rsp.evicted_slot;
		got.live_count = rsp.live_count;
		got.last_result = rsp.last_result;
		if (expected_reports.size() == 0) begin
			$error("result with no item waiting: evicted %0d slot %0d live %0d last %0d",
				got.evicted, got.evicted_slot, got.live_count, got.last_result);
			mismatches++;
		end else begin
			want = expected_reports.pop_front();
			if (got.evicted !== want.evicted) begin
				$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
				mismatches++;
			end
			if (got.evicted_slot !== want.evicted_slot) begin
				$error("evicted_slot: expected %0d, got %0d", want.evicted_slot,
					got.evicted_slot);
				mismatches++;
			end
			if (got.live_count !== want.live_count) begin
				$error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
				mismatches++;
			end
			if (got.last_result !== want.last_result) begin
				$error("last_result: expected %0d, got %0d", want.last_result,
					got.last_result);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_DEPTH; i++)
				slot_st[i] = ST_EMPTY;
			live_slots = '0;
			cursor = '0;
			thr_pct = THR_RESET;
			slots_cfg = SLOTS_RESET;
			expected_reports.delete();
			mismatches = 0;
			awaiting <= 0;
		end else begin
			// Results leave before the item of this edge is predicted, since no item
			// can produce its result on the edge that accepts it.
			if (rsp.valid && rsp.ready)
				check_report();
			if (req.valid && req.ready)
				predict_reports();
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_pct = cfg_wdata[THR_W-1:0];
					REG_SLOTS: slots_cfg = cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			awaiting <= expected_reports.size();
		end
	end

endmodule
`default_nettype wire

[bench/tb_cache_slot_sweep_evictor_core.sv]
// Bench top for cache_slot_sweep_evictor_core: drives directed and random update and
// eviction items under several register settings, with random idling on both channels.
// Depends on csse_pkg, csse_tb_pkg, the channel interfaces and csse_slot_checker.
`default_nettype none
module tb_cache_slot_sweep_evictor_core;
	import csse_pkg::*;
	import csse_tb_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 idle_on;
	int                   mismatches;
	int                   awaiting;
	int                   items_sent;
	int                   evict_checks;
	int                   settings_used;

	csse_req_if req_ch();
	csse_rsp_if rsp_ch();

	cache_slot_sweep_evictor_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	csse_slot_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Result receiver: stalls about a third of the time while idling is enabled.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= arst_n && (!idle_on || $urandom_range(99) >= 33);
		end
	end

	task automatic send_item(input logic fn, input logic [IDX_W-1:0] idx,
		input logic [EP_W-1:0] gep, input logic [EP_W-1:0] vep, input logic vf,
		input logic tf);
		while (idle_on && $urandom_range(99) < 33) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.slot_idx <= idx;
		req_ch.guard_ep <= gep;
		req_ch.vis_ep <= vep;
		req_ch.valid_flag <= vf;
		req_ch.tombstone_flag <= tf;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		if (fn == FN_EVICT)
			evict_checks++;
	endtask

	task automatic send_evict();
		send_item(FN_EVICT, IDX_W'($urandom_range(255)), $urandom, $urandom,
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
	endtask

	task automatic write_settings(input int thr, input int slots);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= CFG_W'(thr);
		@(posedge clk);
		cfg_index <= REG_SLOTS;
		cfg_wdata <= CFG_W'(slots);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int               thr_tab [8];
		int               slot_tab [8];
		int               total;
		logic [IDX_W-1:0] idx;
		logic [EP_W-1:0]  gep;
		logic [EP_W-1:0]  vep;
		thr_tab = '{25, 50, 0, 100, 20, 60, 90, 1};
		slot_tab = '{8, 16, 4, 6, 32, 1, 12, 300};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		req_ch.valid = 1'b0;
		req_ch.func = FN_UPDATE;
		req_ch.slot_idx = '0;
		req_ch.guard_ep = '0;
		req_ch.vis_ep = '0;
		req_ch.valid_flag = 1'b0;
		req_ch.tombstone_flag = 1'b0;
		items_sent = 0;
		evict_checks = 0;
		settings_used = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: live, stale epochs, invalid, tombstone, and a check below threshold.
		send_item(FN_UPDATE, 8'd0, 32'h0, 32'h0, 1'b1, 1'b0);
		send_item(FN_UPDATE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_item(FN_UPDATE, 8'd7, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_item(FN_UPDATE, 8'd8, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0, 1'b0);
		send_item(FN_UPDATE, 8'd9, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b1, 1'b1);
		send_evict();
		send_item(FN_UPDATE, 8'd255, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1);

		// Zero threshold: single evictions, a tombstone eviction, then a fruitless full pass
		// that leaves the cursor far beyond a small slot count.
		write_settings(0, 256);
		send_item(FN_UPDATE, 8'd200, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 1'b0);
		repeat (4) send_evict();

		// Eight slots: the sweep starts at the cursor modulo the slot count and wraps.
		write_settings(0, 8);
		send_item(FN_UPDATE, 8'd0, 32'h1, 32'h1, 1'b1, 1'b0);
		send_item(FN_UPDATE, 8'd3, 32'h2, 32'h2, 1'b1, 1'b0);
		send_item(FN_UPDATE, 8'd5, 32'h3, 32'h3, 1'b1, 1'b1);
		send_item(FN_UPDATE, 8'd12, 32'h4, 32'h4, 1'b1, 1'b0);
		repeat (3) send_evict();

		// No slots in use: eviction does nothing and every update is out of range.
		write_settings(100, 0);
		send_evict();
		send_item(FN_UPDATE, 8'd0, 32'h7, 32'h7, 1'b1, 1'b0);

		// All register bits set; the slot count saturates at the depth.
		write_settings(127, 511);
		send_item(FN_UPDATE, 8'd255, 32'h9, 32'h9, 1'b1, 1'b0);
		send_evict();

		// Full threshold on a single slot.
		write_settings(100, 1);
		send_item(FN_UPDATE, 8'd0, 32'hC, 32'hC, 1'b1, 1'b0);
		send_evict();

		for (int p = 0; p < 8; p++) begin
			write_settings(thr_tab[p], slot_tab[p]);
			// Two phases run with no idling on either side.
			idle_on <= !(p == 3 || p == 4);
			total = (slot_tab[p] > SLOT_DEPTH) ? SLOT_DEPTH : slot_tab[p];
			for (int n = 0; n < 10; n++) begin
				if ($urandom_range(99) < 30) begin
					send_evict();
				end else begin
					if (total > 0 && $urandom_range(99) < 85)
						idx = IDX_W'($urandom_range(total - 1));
					else
						idx = IDX_W'($urandom_range(255));
					gep = $urandom;
					vep = ($urandom_range(99) < 80) ? gep : $urandom;
					send_item(FN_UPDATE, idx, gep, vep, $urandom_range(99) < 85,
						$urandom_range(99) < 20);
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Ran %0d items, %0d of them eviction checks, over %0d register settings.",
			items_sent, evict_checks, settings_used);
		if (mismatches == 0 && awaiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
